// ===== rtl/assert_macros.svh =====
// Assertion macros used by the lookup engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define RLF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition implies another one in the next cycle.
`define RLF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rlf_pkg.sv =====
// Types, codes and field layout of the forwarding lookup engine.
package rlf_pkg;

  localparam int ROUTE_ENTRIES_DEF    = 256;
  localparam int NEIGHBOR_ENTRIES_DEF = 16;
  localparam int NUM_PORTS_DEF        = 4;

  localparam int PORT_W = 2;
  localparam int MAC_W  = 48;
  localparam int IP_W   = 32;
  localparam int TTL_W  = 8;
  localparam int IDX_W  = 8;
  localparam int SLOT_W = 8;
  localparam int OP_W   = 2;
  localparam int STAT_W = 3;

  localparam int ROUTES_REG_W = 9;
  localparam int NBRS_REG_W   = 5;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 9;

  // Input tdata layout, lowest field first.
  localparam int IN_IDX_LSB    = 0;
  localparam int IN_PREFIX_LSB = IN_IDX_LSB + IDX_W;
  localparam int IN_MASK_LSB   = IN_PREFIX_LSB + IP_W;
  localparam int IN_PORT_LSB   = IN_MASK_LSB + IP_W;
  localparam int IN_NIP_LSB    = IN_PORT_LSB + PORT_W;
  localparam int IN_NMAC_LSB   = IN_NIP_LSB + IP_W;
  localparam int IN_DEST_LSB   = IN_NMAC_LSB + MAC_W;
  localparam int IN_TTL_LSB    = IN_DEST_LSB + IP_W;
  localparam int IN_USED_W     = IN_TTL_LSB + TTL_W;
  localparam int IN_TDATA_W    = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata layout, lowest field first.
  localparam int OUT_PORT_LSB = 0;
  localparam int OUT_MAC_LSB  = OUT_PORT_LSB + PORT_W;
  localparam int OUT_TTL_LSB  = OUT_MAC_LSB + MAC_W;
  localparam int OUT_SLOT_LSB = OUT_TTL_LSB + TTL_W;
  localparam int OUT_USED_W   = OUT_SLOT_LSB + SLOT_W;
  localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_WR_ROUTE = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_NBR   = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_FORWARD  = 3'd0;
  localparam logic [STAT_W-1:0] STAT_TTL      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NO_ROUTE = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NO_ARP   = 3'd3;
  localparam logic [STAT_W-1:0] STAT_DONE     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_ROUTES    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBORS = 1'd1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RSCAN,
    S_NSCAN,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic              en;
    logic [IP_W-1:0]   prefix;
    logic [IP_W-1:0]   mask;
    logic [PORT_W-1:0] port;
  } route_wr_t;

  typedef struct packed {
    logic [IP_W-1:0]   prefix;
    logic [IP_W-1:0]   mask;
    logic [PORT_W-1:0] port;
  } route_ent_t;

  typedef struct packed {
    logic             en;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } nbr_wr_t;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } nbr_ent_t;

  typedef struct packed {
    logic            route_mode;
    logic [IP_W-1:0] dest;
    logic [IP_W-1:0] key;
    logic [IP_W-1:0] cmp_val;
    logic [IP_W-1:0] best_mask;
    logic            found;
  } match_req_t;

  typedef struct packed {
    logic hit;
    logic better;
  } match_rsp_t;

endpackage

// ===== rtl/rlf_route_mem.sv =====
// Route table memory: one write port, one registered read port.
module rlf_route_mem #(
  parameter int DEPTH = rlf_pkg::ROUTE_ENTRIES_DEF,
  parameter int AW    = 8
) (
  input  logic               clk_i,
  input  rlf_pkg::route_wr_t wr_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  logic               rd_en_i,
  input  logic [AW-1:0]      rd_addr_i,
  output rlf_pkg::route_ent_t rd_data_o
);

  rlf_pkg::route_ent_t mem [DEPTH];
  rlf_pkg::route_ent_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_addr_i] <= '{prefix: wr_i.prefix, mask: wr_i.mask, port: wr_i.port};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/rlf_nbr_mem.sv =====
// ARP table memory: one write port, one registered read port.
module rlf_nbr_mem #(
  parameter int DEPTH = rlf_pkg::NEIGHBOR_ENTRIES_DEF,
  parameter int AW    = 4
) (
  input  logic              clk_i,
  input  rlf_pkg::nbr_wr_t  wr_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  output rlf_pkg::nbr_ent_t rd_data_o
);

  rlf_pkg::nbr_ent_t mem [DEPTH];
  rlf_pkg::nbr_ent_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_addr_i] <= '{ip: wr_i.ip, mac: wr_i.mac};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/rlf_match_unit.sv =====
// Shared compare unit: masked prefix match for routes, exact match for ARP.
module rlf_match_unit (
  input  rlf_pkg::match_req_t req_i,
  output rlf_pkg::match_rsp_t rsp_o
);

  logic [rlf_pkg::IP_W-1:0] sel_mask;
  logic                     eq;

  // ARP lookups use an all-ones mask so the same equality check serves both.
  assign sel_mask = req_i.route_mode ? req_i.key : '1;
  assign eq       = (req_i.dest & sel_mask) == req_i.cmp_val;

  assign rsp_o.hit    = eq;
  assign rsp_o.better = eq && req_i.route_mode &&
                        (!req_i.found || (req_i.key > req_i.best_mask));

endmodule

// ===== rtl/route_lookup_forward.sv =====
// IPv4 forwarding lookup engine: sequencer, tables and result register.
//
// Usage: one input transaction on the s_axis channel carries an operation in
// tuser: write a route entry, write an ARP entry, or look up a packet. Every
// transaction yields exactly one result transaction on m_axis, with the status
// in tuser. Table writes, unused ops and TTL-zero packets go from acceptance
// straight to the result step. A lookup walks the route table one entry per
// cycle through the shared compare unit, then, if a route matched, the ARP
// table one entry per cycle, stopping at the first ARP hit; each table has a
// single read port. s_axis_tready is high only while the engine is idle, so
// one transaction is in work at a time; the finished result sits in an output
// register and the next transaction is accepted while it waits.
// If m_axis_tready stays low while a second result is ready, the engine holds
// that result and stays busy until the output register is free.
// Reset clears the control state and both in-use registers; table contents are
// undefined until written. The config port writes routes_in_use (index 0) and
// neighbors_in_use (index 1) and must only be used while the engine is idle.
`include "assert_macros.svh"

module route_lookup_forward #(
  parameter int ROUTE_ENTRIES    = rlf_pkg::ROUTE_ENTRIES_DEF,
  parameter int NEIGHBOR_ENTRIES = rlf_pkg::NEIGHBOR_ENTRIES_DEF,
  parameter int NUM_PORTS        = rlf_pkg::NUM_PORTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rlf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rlf_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // entry_index, route_prefix, route_mask, route_port, neighbor_ip,
  // neighbor_mac, dest_addr, hop_limit, zero pad
  input  logic [rlf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // op
  input  logic [rlf_pkg::OP_W-1:0]          s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_port, next_mac, new_hop_limit, route_slot, zero pad
  output logic [rlf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // status
  output logic [rlf_pkg::STAT_W-1:0]        m_axis_tuser
);

  localparam int RAW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int RCW = $clog2(ROUTE_ENTRIES + 1);
  localparam int NAW = (NEIGHBOR_ENTRIES > 1) ? $clog2(NEIGHBOR_ENTRIES) : 1;
  localparam int NCW = $clog2(NEIGHBOR_ENTRIES + 1);

  // Input fields
  logic [rlf_pkg::OP_W-1:0]   in_op;
  logic [rlf_pkg::IDX_W-1:0]  in_idx;
  logic [rlf_pkg::PORT_W-1:0] in_port;
  logic [rlf_pkg::IP_W-1:0]   in_dest;
  logic [rlf_pkg::TTL_W-1:0]  in_ttl;

  assign in_op   = s_axis_tuser;
  assign in_idx  = s_axis_tdata[rlf_pkg::IN_IDX_LSB +: rlf_pkg::IDX_W];
  assign in_port = s_axis_tdata[rlf_pkg::IN_PORT_LSB +: rlf_pkg::PORT_W];
  assign in_dest = s_axis_tdata[rlf_pkg::IN_DEST_LSB +: rlf_pkg::IP_W];
  assign in_ttl  = s_axis_tdata[rlf_pkg::IN_TTL_LSB +: rlf_pkg::TTL_W];

  // Configuration registers
  logic [rlf_pkg::ROUTES_REG_W-1:0] routes_q;
  logic [rlf_pkg::NBRS_REG_W-1:0]   nbrs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      routes_q <= '0;
      nbrs_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rlf_pkg::REG_ROUTES:    routes_q <= cfg_wdata_i;
        rlf_pkg::REG_NEIGHBORS: nbrs_q   <= cfg_wdata_i[rlf_pkg::NBRS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate scan lengths at the table depths.
  logic [RCW-1:0] nr_lim;
  logic [NCW-1:0] nn_lim;

  always_comb begin
    if (32'(routes_q) > 32'(ROUTE_ENTRIES)) begin
      nr_lim = RCW'(ROUTE_ENTRIES);
    end else begin
      nr_lim = RCW'(routes_q);
    end
    if (32'(nbrs_q) > 32'(NEIGHBOR_ENTRIES)) begin
      nn_lim = NCW'(NEIGHBOR_ENTRIES);
    end else begin
      nn_lim = NCW'(nbrs_q);
    end
  end

  // Sequencer state
  rlf_pkg::state_e state_q, state_d;
  logic [RCW-1:0]  ridx_q;
  logic [NCW-1:0]  nidx_q;
  logic            rvld_q;
  logic            nvld_q;
  logic [RAW-1:0]  rslot_q;
  logic            found_q;
  logic            m_tvalid_q;

  logic [rlf_pkg::IP_W-1:0]   dest_q;
  logic [rlf_pkg::TTL_W-1:0]  ttl_q;
  logic [rlf_pkg::IP_W-1:0]   best_mask_q;
  logic [RAW-1:0]             best_slot_q;
  logic [rlf_pkg::PORT_W-1:0] best_port_q;

  logic [rlf_pkg::STAT_W-1:0] res_status_q;
  logic [rlf_pkg::PORT_W-1:0] res_port_q;
  logic [rlf_pkg::MAC_W-1:0]  res_mac_q;
  logic [rlf_pkg::TTL_W-1:0]  res_ttl_q;
  logic [rlf_pkg::SLOT_W-1:0] res_slot_q;

  logic [rlf_pkg::OUT_TDATA_W-1:0] m_tdata_q;
  logic [rlf_pkg::STAT_W-1:0]      m_tuser_q;

  // Control and datapath wiring
  logic                 acc;
  logic                 out_free;
  logic                 r_rd_en;
  logic                 n_rd_en;
  logic                 r_done;
  logic                 n_done;
  logic                 n_hit;
  rlf_pkg::route_wr_t   route_wr;
  rlf_pkg::nbr_wr_t     nbr_wr;
  logic [RAW-1:0]       route_wr_addr;
  logic [NAW-1:0]       nbr_wr_addr;
  rlf_pkg::route_ent_t  route_rd;
  rlf_pkg::nbr_ent_t    nbr_rd;
  rlf_pkg::match_req_t  mreq;
  rlf_pkg::match_rsp_t  mrsp;

  assign acc      = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_tvalid_q || m_axis_tready;
  assign r_done   = (ridx_q == nr_lim) && !rvld_q;
  assign n_done   = (nidx_q == nn_lim) && !nvld_q;
  assign n_hit    = nvld_q && mrsp.hit;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rlf_pkg::S_IDLE: begin
        if (acc) begin
          if (in_op == rlf_pkg::OP_LOOKUP && in_ttl != '0) begin
            state_d = rlf_pkg::S_RSCAN;
          end else begin
            state_d = rlf_pkg::S_RESULT;
          end
        end
      end
      rlf_pkg::S_RSCAN: begin
        if (r_done) begin
          state_d = found_q ? rlf_pkg::S_NSCAN : rlf_pkg::S_RESULT;
        end
      end
      rlf_pkg::S_NSCAN: begin
        if (n_hit || n_done) begin
          state_d = rlf_pkg::S_RESULT;
        end
      end
      rlf_pkg::S_RESULT: begin
        if (out_free) begin
          state_d = rlf_pkg::S_IDLE;
        end
      end
      default: state_d = rlf_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = (state_q == rlf_pkg::S_IDLE);
    r_rd_en       = (state_q == rlf_pkg::S_RSCAN) && (ridx_q < nr_lim);
    n_rd_en       = (state_q == rlf_pkg::S_NSCAN) && (nidx_q < nn_lim) && !n_hit;

    route_wr.en     = acc && (in_op == rlf_pkg::OP_WR_ROUTE) &&
                      (32'(in_idx) < 32'(ROUTE_ENTRIES)) &&
                      (32'(in_port) < 32'(NUM_PORTS));
    route_wr.prefix = s_axis_tdata[rlf_pkg::IN_PREFIX_LSB +: rlf_pkg::IP_W];
    route_wr.mask   = s_axis_tdata[rlf_pkg::IN_MASK_LSB +: rlf_pkg::IP_W];
    route_wr.port   = in_port;
    route_wr_addr   = RAW'(in_idx);

    nbr_wr.en   = acc && (in_op == rlf_pkg::OP_WR_NBR) &&
                  (32'(in_idx) < 32'(NEIGHBOR_ENTRIES));
    nbr_wr.ip   = s_axis_tdata[rlf_pkg::IN_NIP_LSB +: rlf_pkg::IP_W];
    nbr_wr.mac  = s_axis_tdata[rlf_pkg::IN_NMAC_LSB +: rlf_pkg::MAC_W];
    nbr_wr_addr = NAW'(in_idx);

    mreq.route_mode = (state_q == rlf_pkg::S_RSCAN);
    mreq.dest       = dest_q;
    mreq.key        = route_rd.mask;
    mreq.cmp_val    = mreq.route_mode ? route_rd.prefix : nbr_rd.ip;
    mreq.best_mask  = best_mask_q;
    mreq.found      = found_q;
  end

  rlf_route_mem #(
    .DEPTH (ROUTE_ENTRIES),
    .AW    (RAW)
  ) u_route_mem (
    .clk_i     (clk_i),
    .wr_i      (route_wr),
    .wr_addr_i (route_wr_addr),
    .rd_en_i   (r_rd_en),
    .rd_addr_i (ridx_q[RAW-1:0]),
    .rd_data_o (route_rd)
  );

  rlf_nbr_mem #(
    .DEPTH (NEIGHBOR_ENTRIES),
    .AW    (NAW)
  ) u_nbr_mem (
    .clk_i     (clk_i),
    .wr_i      (nbr_wr),
    .wr_addr_i (nbr_wr_addr),
    .rd_en_i   (n_rd_en),
    .rd_addr_i (nidx_q[NAW-1:0]),
    .rd_data_o (nbr_rd)
  );

  rlf_match_unit u_match (
    .req_i (mreq),
    .rsp_o (mrsp)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= rlf_pkg::S_IDLE;
      ridx_q     <= '0;
      nidx_q     <= '0;
      rvld_q     <= 1'b0;
      nvld_q     <= 1'b0;
      found_q    <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rvld_q  <= r_rd_en;
      nvld_q  <= n_rd_en;
      if (acc) begin
        ridx_q  <= '0;
        nidx_q  <= '0;
        found_q <= 1'b0;
      end
      if (r_rd_en) begin
        ridx_q <= ridx_q + 1'b1;
      end
      if (n_rd_en) begin
        nidx_q <= nidx_q + 1'b1;
      end
      if (state_q == rlf_pkg::S_RSCAN && rvld_q && mrsp.better) begin
        found_q <= 1'b1;
      end
      if (state_q == rlf_pkg::S_RESULT && out_free) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (acc) begin
      dest_q       <= in_dest;
      ttl_q        <= in_ttl;
      res_port_q   <= '0;
      res_mac_q    <= '0;
      res_ttl_q    <= '0;
      res_slot_q   <= '0;
      if (in_op == rlf_pkg::OP_LOOKUP && in_ttl == '0) begin
        res_status_q <= rlf_pkg::STAT_TTL;
      end else begin
        res_status_q <= rlf_pkg::STAT_DONE;
      end
    end
    if (r_rd_en) begin
      rslot_q <= ridx_q[RAW-1:0];
    end
    if (state_q == rlf_pkg::S_RSCAN) begin
      if (rvld_q && mrsp.better) begin
        best_mask_q <= route_rd.mask;
        best_slot_q <= rslot_q;
        best_port_q <= route_rd.port;
      end
      if (r_done) begin
        if (found_q) begin
          res_status_q <= rlf_pkg::STAT_NO_ARP;
          res_port_q   <= best_port_q;
          res_ttl_q    <= ttl_q - 1'b1;
          res_slot_q   <= rlf_pkg::SLOT_W'(best_slot_q);
        end else begin
          res_status_q <= rlf_pkg::STAT_NO_ROUTE;
        end
      end
    end
    if (state_q == rlf_pkg::S_NSCAN && n_hit) begin
      res_status_q <= rlf_pkg::STAT_FORWARD;
      res_mac_q    <= nbr_rd.mac;
    end
    // Load the output register once it is free.
    if (state_q == rlf_pkg::S_RESULT && out_free) begin
      m_tdata_q <= rlf_pkg::OUT_TDATA_W'({res_slot_q, res_ttl_q, res_mac_q, res_port_q});
      m_tuser_q <= res_status_q;
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

  `RLF_ASSERT(a_rvld_follows_read, rvld_q |-> $past(r_rd_en),
    "route data marked valid without a read in the previous cycle")
  `RLF_ASSERT(a_result_from_seq, $rose(m_axis_tvalid) |-> $past(state_q == rlf_pkg::S_RESULT),
    "output became valid outside the result step")
  `RLF_ASSERT(a_nscan_needs_route,
    (state_q == rlf_pkg::S_NSCAN) |-> (found_q && ({1'b0, best_slot_q} < (RAW + 1)'(nr_lim))),
    "ARP scan started without a valid winning route")
  `RLF_ASSERT_NEXT(a_accept_leaves_idle, acc, state_q != rlf_pkg::S_IDLE,
    "engine stayed idle after accepting a transaction")

endmodule

// ===== tb/tb_route_lookup_forward.sv =====
// Self-checking testbench for the route_lookup_forward IPv4 lookup engine.
module tb_route_lookup_forward;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_ROUTES     = rlf_pkg::ROUTE_ENTRIES_DEF;
  localparam int N_NBRS       = rlf_pkg::NEIGHBOR_ENTRIES_DEF;
  localparam int N_PORTS      = rlf_pkg::NUM_PORTS_DEF;
  localparam int N_STATUS     = int'(rlf_pkg::STAT_DONE) + 1;
  localparam int NET_POOL     = 8;
  localparam int PHASES       = 24;
  localparam int PHASE_ITEMS  = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 3000;
  localparam int SETTLE       = 8;
  localparam int MAX_REPORTS  = 10;

  localparam logic [rlf_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [rlf_pkg::OP_W-1:0]   op;
    logic [rlf_pkg::IDX_W-1:0]  entry_index;
    logic [rlf_pkg::IP_W-1:0]   route_prefix;
    logic [rlf_pkg::IP_W-1:0]   route_mask;
    logic [rlf_pkg::PORT_W-1:0] route_port;
    logic [rlf_pkg::IP_W-1:0]   neighbor_ip;
    logic [rlf_pkg::MAC_W-1:0]  neighbor_mac;
    logic [rlf_pkg::IP_W-1:0]   dest_addr;
    logic [rlf_pkg::TTL_W-1:0]  hop_limit;
  } lookup_item_t;

  typedef struct packed {
    logic [rlf_pkg::STAT_W-1:0] status;
    logic [rlf_pkg::PORT_W-1:0] out_port;
    logic [rlf_pkg::MAC_W-1:0]  next_mac;
    logic [rlf_pkg::TTL_W-1:0]  new_hop;
    logic [rlf_pkg::SLOT_W-1:0] route_slot;
  } fwd_result_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [rlf_pkg::CFG_IDX_W-1:0]   cfg_idx_i;
  logic [rlf_pkg::CFG_DATA_W-1:0]  cfg_wdata_i;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  // entry_index, route_prefix, route_mask, route_port, neighbor_ip,
  // neighbor_mac, dest_addr, hop_limit, zero pad
  logic [rlf_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  // op
  logic [rlf_pkg::OP_W-1:0]        s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  // out_port, next_mac, new_hop_limit, route_slot, zero pad
  logic [rlf_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  // status
  logic [rlf_pkg::STAT_W-1:0]      m_axis_tuser;

  // Shadow copy of the engine tables and size registers
  logic [rlf_pkg::IP_W-1:0]   route_prefix_tbl [N_ROUTES];
  logic [rlf_pkg::IP_W-1:0]   route_mask_tbl   [N_ROUTES];
  logic [rlf_pkg::PORT_W-1:0] route_port_tbl   [N_ROUTES];
  logic [rlf_pkg::IP_W-1:0]   nbr_ip_tbl       [N_NBRS];
  logic [rlf_pkg::MAC_W-1:0]  nbr_mac_tbl      [N_NBRS];
  logic [rlf_pkg::ROUTES_REG_W-1:0] cfg_routes;
  logic [rlf_pkg::NBRS_REG_W-1:0]   cfg_nbrs;
  logic [rlf_pkg::IP_W-1:0]   net_pool [NET_POOL];

  fwd_result_t pending_results[$];

  int  error_count;
  int  results_checked;
  int  items_sent;
  int  lookups_sent;
  int  status_count [N_STATUS];
  bit  steady_mode;
  bit  hold_request;

  route_lookup_forward u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic fwd_result_t predict_result(input lookup_item_t it);
    fwd_result_t r;
    int          n_routes;
    int          n_nbrs;
    logic        found;
    logic [31:0] best_mask;
    int          best_slot;
    r         = '0;
    r.status  = rlf_pkg::STAT_DONE;
    found     = 1'b0;
    best_mask = '0;
    best_slot = 0;
    case (it.op)
      rlf_pkg::OP_WR_ROUTE: begin
        if (it.entry_index < N_ROUTES && it.route_port < N_PORTS) begin
          route_prefix_tbl[it.entry_index] = it.route_prefix;
          route_mask_tbl[it.entry_index]   = it.route_mask;
          route_port_tbl[it.entry_index]   = it.route_port;
        end
      end
      rlf_pkg::OP_WR_NBR: begin
        if (it.entry_index < N_NBRS) begin
          nbr_ip_tbl[it.entry_index]  = it.neighbor_ip;
          nbr_mac_tbl[it.entry_index] = it.neighbor_mac;
        end
      end
      rlf_pkg::OP_LOOKUP: begin
        if (it.hop_limit == '0) begin
          r.status = rlf_pkg::STAT_TTL;
        end else begin
          n_routes = (cfg_routes > N_ROUTES) ? N_ROUTES : int'(cfg_routes);
          for (int i = 0; i < n_routes; i++) begin
            if ((it.dest_addr & route_mask_tbl[i]) == route_prefix_tbl[i] &&
                (!found || route_mask_tbl[i] > best_mask)) begin
              found     = 1'b1;
              best_mask = route_mask_tbl[i];
              best_slot = i;
            end
          end
          if (!found) begin
            r.status = rlf_pkg::STAT_NO_ROUTE;
          end else begin
            r.status     = rlf_pkg::STAT_NO_ARP;
            r.out_port   = route_port_tbl[best_slot];
            r.new_hop    = it.hop_limit - 1'b1;
            r.route_slot = best_slot[rlf_pkg::SLOT_W-1:0];
            n_nbrs = (cfg_nbrs > N_NBRS) ? N_NBRS : int'(cfg_nbrs);
            // first ARP hit wins
            for (int i = 0; i < n_nbrs; i++) begin
              if (r.status == rlf_pkg::STAT_NO_ARP && nbr_ip_tbl[i] == it.dest_addr) begin
                r.status   = rlf_pkg::STAT_FORWARD;
                r.next_mac = nbr_mac_tbl[i];
              end
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] len_mask(input int len);
    if (len <= 0)
      return '0;
    return 32'hFFFF_FFFF << (32 - len);
  endfunction

  function automatic logic [rlf_pkg::MAC_W-1:0] random_mac();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[rlf_pkg::MAC_W-1:0];
  endfunction

  // All fields random; callers overwrite the ones the op uses.
  function automatic lookup_item_t random_item();
    lookup_item_t it;
    it.op           = rlf_pkg::OP_W'($urandom_range(3));
    it.entry_index  = rlf_pkg::IDX_W'($urandom_range(255));
    it.route_prefix = $urandom;
    it.route_mask   = $urandom;
    it.route_port   = rlf_pkg::PORT_W'($urandom_range(3));
    it.neighbor_ip  = $urandom;
    it.neighbor_mac = random_mac();
    it.dest_addr    = $urandom;
    it.hop_limit    = rlf_pkg::TTL_W'($urandom_range(255));
    return it;
  endfunction

  function automatic lookup_item_t mk_route(input int slot, input logic [31:0] prefix,
                                            input logic [31:0] mask,
                                            input logic [rlf_pkg::PORT_W-1:0] port);
    lookup_item_t it;
    it              = random_item();
    it.op           = rlf_pkg::OP_WR_ROUTE;
    it.entry_index  = slot[rlf_pkg::IDX_W-1:0];
    it.route_prefix = prefix;
    it.route_mask   = mask;
    it.route_port   = port;
    return it;
  endfunction

  function automatic lookup_item_t mk_nbr(input int slot, input logic [31:0] ip,
                                          input logic [rlf_pkg::MAC_W-1:0] mac);
    lookup_item_t it;
    it              = random_item();
    it.op           = rlf_pkg::OP_WR_NBR;
    it.entry_index  = slot[rlf_pkg::IDX_W-1:0];
    it.neighbor_ip  = ip;
    it.neighbor_mac = mac;
    return it;
  endfunction

  function automatic lookup_item_t mk_lookup(input logic [31:0] dest,
                                             input logic [rlf_pkg::TTL_W-1:0] ttl);
    lookup_item_t it;
    it           = random_item();
    it.op        = rlf_pkg::OP_LOOKUP;
    it.dest_addr = dest;
    it.hop_limit = ttl;
    return it;
  endfunction

  // Mostly prefixes from a few networks, so that routes overlap and tie.
  function automatic lookup_item_t route_write_item(input int slot);
    int          pick;
    logic [31:0] m;
    logic [31:0] p;
    pick = $urandom_range(19);
    if (pick < 2)
      m = '0;
    else if (pick < 4)
      m = '1;
    else if (pick == 4)
      m = $urandom;
    else if (pick < 12)
      m = len_mask(8 * $urandom_range(1, 3));
    else
      m = len_mask($urandom_range(1, 31));
    if ($urandom_range(9) == 0)
      p = $urandom;
    else
      p = net_pool[$urandom_range(NET_POOL - 1)] & m;
    return mk_route(slot, p, m, rlf_pkg::PORT_W'($urandom_range(3)));
  endfunction

  function automatic lookup_item_t nbr_write_item(input int slot);
    logic [31:0] ip;
    ip = net_pool[$urandom_range(NET_POOL - 1)] ^
         ($urandom & ~len_mask($urandom_range(16, 32)));
    return mk_nbr(slot, ip, random_mac());
  endfunction

  function automatic lookup_item_t lookup_item();
    int          pick;
    int          slot;
    logic [31:0] dest;
    logic [31:0] m;
    logic [rlf_pkg::TTL_W-1:0] ttl;
    pick = $urandom_range(9);
    if (pick < 4) begin
      dest = nbr_ip_tbl[$urandom_range(N_NBRS - 1)];
    end else if (pick < 7) begin
      m    = len_mask($urandom_range(32));
      dest = (net_pool[$urandom_range(NET_POOL - 1)] & m) | ($urandom & ~m);
    end else if (pick == 7) begin
      dest = $urandom;
    end else if (pick == 8) begin
      slot = $urandom_range(N_ROUTES - 1);
      dest = route_prefix_tbl[slot] | ($urandom & ~route_mask_tbl[slot]);
    end else begin
      dest = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
    end
    pick = $urandom_range(19);
    if (pick == 0)
      ttl = '0;
    else if (pick == 1)
      ttl = 8'd1;
    else if (pick == 2)
      ttl = 8'hFF;
    else
      ttl = rlf_pkg::TTL_W'($urandom_range(255));
    return mk_lookup(dest, ttl);
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic send_item(input lookup_item_t it);
    logic [rlf_pkg::IN_TDATA_W-1:0] data;
    if (!steady_mode && $urandom_range(99) < 19) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    data = '0;
    data[rlf_pkg::IN_IDX_LSB    +: rlf_pkg::IDX_W]  = it.entry_index;
    data[rlf_pkg::IN_PREFIX_LSB +: rlf_pkg::IP_W]   = it.route_prefix;
    data[rlf_pkg::IN_MASK_LSB   +: rlf_pkg::IP_W]   = it.route_mask;
    data[rlf_pkg::IN_PORT_LSB   +: rlf_pkg::PORT_W] = it.route_port;
    data[rlf_pkg::IN_NIP_LSB    +: rlf_pkg::IP_W]   = it.neighbor_ip;
    data[rlf_pkg::IN_NMAC_LSB   +: rlf_pkg::MAC_W]  = it.neighbor_mac;
    data[rlf_pkg::IN_DEST_LSB   +: rlf_pkg::IP_W]   = it.dest_addr;
    data[rlf_pkg::IN_TTL_LSB    +: rlf_pkg::TTL_W]  = it.hop_limit;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    pending_results.push_back(predict_result(it));
    items_sent++;
    if (it.op == rlf_pkg::OP_LOOKUP)
      lookups_sent++;
  endtask

  // Drop valid, wait for every outstanding result, then let the engine settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_table_sizes(input logic [rlf_pkg::CFG_DATA_W-1:0] routes,
                                   input logic [rlf_pkg::CFG_DATA_W-1:0] nbrs);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= rlf_pkg::REG_ROUTES;
    cfg_wdata_i <= routes;
    @(posedge clk_i);
    cfg_idx_i   <= rlf_pkg::REG_NEIGHBORS;
    cfg_wdata_i <= nbrs;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_routes = routes[rlf_pkg::ROUTES_REG_W-1:0];
    cfg_nbrs   = nbrs[rlf_pkg::NBRS_REG_W-1:0];
  endtask

  task automatic test_directed();
    lookup_item_t it;
    // empty tables, both sizes zero after reset
    send_item(mk_lookup(32'h0A01_0203, 8'd0));
    send_item(mk_lookup(32'h0A01_0203, 8'd64));
    it    = random_item();
    it.op = OP_UNUSED;
    send_item(it);
    // slot past the ARP table: ignored
    send_item(mk_nbr(N_NBRS, 32'h0A01_0203, 48'h1234_5678_9ABC));
    send_item(mk_route(0, 32'h0, 32'h0, 2'd3));
    send_item(mk_route(1, 32'h0A00_0000, 32'hFF00_0000, 2'd1));
    send_item(mk_route(2, 32'h0A01_0000, 32'hFFFF_0000, 2'd2));
    send_item(mk_route(3, 32'h0A01_0000, 32'hFFFF_0000, 2'd0));
    send_item(mk_route(4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd2));
    send_item(mk_nbr(0, 32'h0A01_0203, 48'hFFFF_FFFF_FFFF));
    send_item(mk_nbr(1, 32'hFFFF_FFFF, 48'h0));
    send_item(mk_nbr(2, 32'h0A09_0909, 48'h0200_5E00_0001));
    send_item(mk_nbr(3, 32'h0, 48'h1));
    wait_idle();
    write_table_sizes(9'd5, 9'd4);
    send_item(mk_lookup(32'h0A01_0203, 8'hFF));  // tie on /16, lower slot wins
    send_item(mk_lookup(32'hFFFF_FFFF, 8'd1));   // host route, TTL goes to zero
    send_item(mk_lookup(32'h0A09_0909, 8'd17));
    send_item(mk_lookup(32'h0B00_0000, 8'd9));   // default route, no ARP entry
    send_item(mk_lookup(32'h0, 8'd128));
    wait_idle();
    write_table_sizes(9'd2, 9'd0);
    send_item(mk_lookup(32'h0A01_0203, 8'd2));
    wait_idle();
    write_table_sizes(9'd1, 9'd4);
    send_item(mk_lookup(32'h0A01_0203, 8'd3));
    wait_idle();
  endtask

  // Write every slot so that later scans never touch an unwritten entry.
  task automatic test_fill_tables();
    for (int i = 0; i < NET_POOL; i++)
      net_pool[i] = $urandom;
    for (int s = 0; s < N_ROUTES; s++)
      send_item(route_write_item(s));
    for (int s = 0; s < N_NBRS; s++)
      send_item(nbr_write_item(s));
    wait_idle();
  endtask

  task automatic test_backpressure();
    lookup_item_t it;
    hold_request = 1'b1;
    for (int n = 0; n < 16; n++) begin
      case (n % 4)
        0: send_item(mk_lookup($urandom, 8'd0));
        1: send_item(route_write_item($urandom_range(N_ROUTES - 1)));
        2: send_item(nbr_write_item($urandom_range(N_NBRS - 1)));
        default: begin
          it    = random_item();
          it.op = OP_UNUSED;
          send_item(it);
        end
      endcase
    end
    wait_idle();
  endtask

  task automatic test_random_traffic();
    logic [rlf_pkg::CFG_DATA_W-1:0] routes;
    logic [rlf_pkg::CFG_DATA_W-1:0] nbrs;
    lookup_item_t it;
    int pick;
    for (int ph = 0; ph < PHASES; ph++) begin
      pick = $urandom_range(9);
      case (pick)
        0:       routes = 9'd0;
        1:       routes = 9'd1;
        2, 3, 4: routes = rlf_pkg::CFG_DATA_W'($urandom_range(2, 16));
        5, 6:    routes = rlf_pkg::CFG_DATA_W'($urandom_range(17, 64));
        7:       routes = 9'd256;
        8:       routes = rlf_pkg::CFG_DATA_W'($urandom_range(257, 511));
        default: routes = rlf_pkg::CFG_DATA_W'($urandom_range(65, 255));
      endcase
      pick = $urandom_range(5);
      case (pick)
        0:       nbrs = 9'd0;
        1:       nbrs = 9'd16;
        2:       nbrs = rlf_pkg::CFG_DATA_W'($urandom_range(17, 31));
        default: nbrs = rlf_pkg::CFG_DATA_W'($urandom_range(1, 15));
      endcase
      case (ph)
        0: begin routes = 9'd256; nbrs = 9'd16; end
        1: begin routes = 9'd0;   nbrs = 9'd0;  end
        2: begin routes = 9'd511; nbrs = 9'd31; end
        3: nbrs = 9'h1E5;  // upper data bits fall outside the register
        default: ;
      endcase
      steady_mode = (ph == 6 || ph == 7);
      write_table_sizes(routes, nbrs);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 64) begin
          it = lookup_item();
        end else if (pick < 78) begin
          it = route_write_item($urandom_range(N_ROUTES - 1));
        end else if (pick < 88) begin
          if ($urandom_range(3) == 0)
            it = nbr_write_item($urandom_range(N_NBRS, 255));
          else
            it = nbr_write_item($urandom_range(N_NBRS - 1));
        end else if (pick < 92) begin
          it    = random_item();
          it.op = OP_UNUSED;
        end else begin
          it           = lookup_item();
          it.hop_limit = '0;
        end
        send_item(it);
      end
      wait_idle();
    end
    steady_mode = 1'b0;
  endtask

  // Result receiver: random stalls, one long hold when asked.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++)
          @(posedge clk_i);
      end else begin
        m_axis_tready <= steady_mode || ($urandom_range(99) >= 19);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    fwd_result_t got;
    fwd_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status     = m_axis_tuser;
      got.out_port   = m_axis_tdata[rlf_pkg::OUT_PORT_LSB +: rlf_pkg::PORT_W];
      got.next_mac   = m_axis_tdata[rlf_pkg::OUT_MAC_LSB  +: rlf_pkg::MAC_W];
      got.new_hop    = m_axis_tdata[rlf_pkg::OUT_TTL_LSB  +: rlf_pkg::TTL_W];
      got.route_slot = m_axis_tdata[rlf_pkg::OUT_SLOT_LSB +: rlf_pkg::SLOT_W];
      results_checked++;
      if (got.status <= rlf_pkg::STAT_DONE)
        status_count[got.status]++;
      if (pending_results.size() == 0) begin
        flag_error($sformatf("result with nothing outstanding: status %0d", got.status));
      end else begin
        want = pending_results.pop_front();
        if (got !== want)
          flag_error($sformatf({"result %0d: expected status %0d port %0d mac %h ttl %0d ",
                                "slot %0d, got status %0d port %0d mac %h ttl %0d slot %0d"},
                               results_checked, want.status, want.out_port, want.next_mac,
                               want.new_hop, want.route_slot, got.status, got.out_port,
                               got.next_mac, got.new_hop, got.route_slot));
      end
    end
  end

  // Watchdog: end the run if no transaction moves on either side for too long.
  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("no transaction for %0d cycles, %0d results outstanding",
             STALL_LIMIT, pending_results.size());
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_routes    = '0;
    cfg_nbrs      = '0;
    steady_mode   = 1'b0;
    hold_request  = 1'b0;
    error_count   = 0;
    results_checked = 0;
    items_sent    = 0;
    lookups_sent  = 0;
    for (int i = 0; i < N_STATUS; i++)
      status_count[i] = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_fill_tables();
    test_backpressure();
    test_random_traffic();
    wait_idle();

    if (pending_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_results.size()));
    $display("sent %0d transactions (%0d lookups), checked %0d results, %0d errors",
             items_sent, lookups_sent, results_checked, error_count);
    $display("status mix: forward %0d, ttl expired %0d, no route %0d, no arp %0d, done %0d",
             status_count[rlf_pkg::STAT_FORWARD], status_count[rlf_pkg::STAT_TTL],
             status_count[rlf_pkg::STAT_NO_ROUTE], status_count[rlf_pkg::STAT_NO_ARP],
             status_count[rlf_pkg::STAT_DONE]);
    if (error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rlf_pkg.sv
rtl/rlf_route_mem.sv
rtl/rlf_nbr_mem.sv
rtl/rlf_match_unit.sv
rtl/route_lookup_forward.sv
tb/tb_route_lookup_forward.sv
